### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the checker RTL. Expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked outside reset
`define CHK_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every edge, reset included
`define CHK_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/mchk_pkg.sv
// ----------------------------------------------------------------------------
// mchk_pkg
// Types and constants for the memory access checker with stack mark.
// ----------------------------------------------------------------------------
`default_nettype none

package mchk_pkg;

  localparam logic [37:0] ADDR_MAX  = 38'h3f_ffff_ffff;
  localparam logic [31:0] MARK_MASK = 32'hffff_fff0;

  // Configuration register indexes
  localparam logic [1:0] CFG_MIN_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_MAX_ADDRESS = 2'd1;
  localparam logic [1:0] CFG_STACK_BASE  = 2'd2;

  typedef enum logic [1:0] {
    MODE_LOAD       = 2'd0,
    MODE_STORE      = 2'd1,
    MODE_MARK_WRITE = 2'd2,
    MODE_UNUSED     = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    FAULT_NONE             = 3'd0,
    FAULT_LOAD_MISALIGNED  = 3'd1,
    FAULT_LOAD_ACCESS      = 3'd2,
    FAULT_STORE_MISALIGNED = 3'd3,
    FAULT_STORE_ACCESS     = 3'd4
  } fault_t;

  typedef struct packed {
    logic [37:0] min_address;
    logic [37:0] max_address;
    logic [31:0] stack_base;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [37:0] address;
    logic [1:0]  access_size_log2;
    logic [31:0] instruction_address;
  } item_t;

  typedef struct packed {
    fault_t      fault_code;
    logic        forward;
    logic [37:0] tval;
    logic [31:0] fault_pc;
    logic [31:0] mark_now;
  } res_t;

endpackage

`default_nettype wire

### src/mchk_cfg.sv
// ----------------------------------------------------------------------------
// mchk_cfg
// Configuration registers: address window and stack base, with clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module mchk_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [1:0]         cfg_index,
  input  logic [37:0]        cfg_data,
  output mchk_pkg::cfg_t     cfg
);
  import mchk_pkg::*;

  logic [37:0] min_address;
  logic [37:0] max_address;
  logic [31:0] stack_base;
  logic [37:0] min_address_next;

  // min is clamped to the current max; max needs no clamp at 38 bits
  assign min_address_next = (cfg_data < max_address) ? cfg_data : max_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_address <= '0;
      max_address <= ADDR_MAX;
      stack_base  <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_MIN_ADDRESS: min_address <= min_address_next;
        CFG_MAX_ADDRESS: max_address <= cfg_data;
        CFG_STACK_BASE:  stack_base  <= cfg_data[31:0] & MARK_MASK;
        default: ;
      endcase
    end
  end

  assign cfg.min_address = min_address;
  assign cfg.max_address = max_address;
  assign cfg.stack_base  = stack_base;

endmodule

`default_nettype wire

### src/mchk_eval.sv
// ----------------------------------------------------------------------------
// mchk_eval
// Alignment and window checks, fault reporting and mark update for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module mchk_eval (
  input  mchk_pkg::item_t item,
  input  mchk_pkg::cfg_t  cfg,
  input  logic [31:0]     mark,
  output mchk_pkg::res_t  res,
  output logic [31:0]     mark_next
);
  import mchk_pkg::*;

  logic        is_access;
  logic        is_store;
  logic        misaligned;
  logic        outside;
  logic [31:0] a32;
  logic        in_stack;

  assign is_access = (item.mode == MODE_LOAD) || (item.mode == MODE_STORE);
  assign is_store  = (item.mode == MODE_STORE);
  assign a32       = item.address[31:0];

  // low address bits that must be zero for the access size
  always_comb begin
    case (item.access_size_log2)
      2'd0:    misaligned = 1'b0;
      2'd1:    misaligned = item.address[0];
      2'd2:    misaligned = |item.address[1:0];
      2'd3:    misaligned = |item.address[2:0];
      default: misaligned = 1'b0;
    endcase
  end

  assign outside  = (item.address < cfg.min_address) || (item.address > cfg.max_address);
  assign in_stack = (a32 >= cfg.stack_base) && (a32 < mark);

  // fault priority: misaligned, then window; trap value and pc only on a fault
  always_comb begin
    res.fault_code = FAULT_NONE;
    res.forward    = 1'b0;
    res.tval       = '0;
    res.fault_pc   = '0;
    mark_next      = mark;
    if (is_access) begin
      if (misaligned) begin
        res.fault_code = is_store ? FAULT_STORE_MISALIGNED : FAULT_LOAD_MISALIGNED;
      end else if (outside) begin
        res.fault_code = is_store ? FAULT_STORE_ACCESS : FAULT_LOAD_ACCESS;
      end else begin
        res.forward = 1'b1;
        if (is_store && in_stack) begin
          mark_next = a32 & MARK_MASK;
        end
      end
    end else if (item.mode == MODE_MARK_WRITE) begin
      mark_next = a32 & MARK_MASK;
    end
    if (res.fault_code != FAULT_NONE) begin
      res.tval     = item.address;
      res.fault_pc = item.instruction_address;
    end
    res.mark_now = mark_next;
  end

endmodule

`default_nettype wire

### src/memory_access_checker_stack_hwm.sv
// Path: an accepted item is held in the input stage register, then evaluated and
//   registered in the result register once that register is free or drained.
// Throughput: one item per cycle while results are taken; the mark register is updated
//   as an item enters the result register, so the next item sees it at once.
// Reset: clears both valid flags and the mark, window to the full range, stack base zero.
// ----------------------------------------------------------------------------
// memory_access_checker_stack_hwm
// Scalar load/store access checker with stack high-water mark tracking.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module memory_access_checker_stack_hwm (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [37:0] cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [37:0] address,
  input  logic [1:0]  access_size_log2,
  input  logic [31:0] instruction_address,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  fault_code,
  output logic        forward,
  output logic [37:0] tval,
  output logic [31:0] fault_pc,
  output logic [31:0] mark_now
);
  import mchk_pkg::*;

  cfg_t        cfg;
  logic        s1_valid;
  item_t       s1_item;
  logic        s1_advance;
  logic [31:0] mark;
  logic [31:0] mark_next;
  res_t        res_next;
  res_t        res;

  mchk_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mchk_eval u_eval (
    .item      (s1_item),
    .cfg       (cfg),
    .mark      (mark),
    .res       (res_next),
    .mark_next (mark_next)
  );

  // handshake: input stage moves on when the result register is free or drained
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      mark      <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_advance) begin
        out_valid <= 1'b1;
        mark      <= mark_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.mode                <= mode_t'(mode);
      s1_item.address             <= address;
      s1_item.access_size_log2    <= access_size_log2;
      s1_item.instruction_address <= instruction_address;
    end
    if (s1_advance) begin
      res <= res_next;
    end
  end

  assign fault_code = res.fault_code;
  assign forward    = res.forward;
  assign tval       = res.tval;
  assign fault_pc   = res.fault_pc;
  assign mark_now   = res.mark_now;

  // checks
  `CHK_ASSERT(a_mark_granule, mark[3:0] == 4'd0, "mark not 16-byte aligned")
  `CHK_ASSERT(a_fwd_no_fault, out_valid && forward |-> res.fault_code == FAULT_NONE,
              "forwarded item carries a fault")
  `CHK_ASSERT(a_clean_zero,
              out_valid && res.fault_code == FAULT_NONE |-> tval == '0 && fault_pc == '0,
              "trap info without fault")
  `CHK_ASSERT(a_mark_moves, !$stable(mark) |-> $past(rst) || $past(s1_advance),
              "mark changed without an item")
  `CHK_ASSERT(a_result_mark, $past(s1_advance) |-> mark_now == mark,
              "result mark differs from mark register")

endmodule

`default_nettype wire

### tb/tb_memory_access_checker_stack_hwm.sv
// ----------------------------------------------------------------------------
// tb_memory_access_checker_stack_hwm
// Self-checking bench for the access checker with stack high-water mark.
// A directed run covers alignment, window edges, an upside-down window, mark
// writes and stack stores. Random blocks of items then run under changing
// windows and stack bases. Each accepted item is predicted, and each result
// is compared field by field in order. Both channels idle at random, and the
// result side stalls for long stretches so that the block backs up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_memory_access_checker_stack_hwm;
  import mchk_pkg::*;

  // Index outside the register map; the block must ignore writes to it
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // Expected access verdicts, predicted as each item is accepted
  class access_verdict_board;
    logic [37:0] win_lo;
    logic [37:0] win_hi;
    logic [31:0] stack_base;
    logic [31:0] hwm;
    res_t        verdicts_due[$];
    int          mismatches;
    int          results_seen;

    function new();
      win_lo       = '0;
      win_hi       = ADDR_MAX;
      stack_base   = '0;
      hwm          = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void note_config(logic [1:0] idx, logic [37:0] data);
      case (idx)
        CFG_MIN_ADDRESS: win_lo = (data < win_hi) ? data : win_hi;
        // a 38-bit write can never exceed the top of the address space
        CFG_MAX_ADDRESS: win_hi = data;
        CFG_STACK_BASE:  stack_base = data[31:0] & MARK_MASK;
        default: ;
      endcase
    endfunction

    // Work out the verdict of one access and queue it
    function void predict_access(item_t it);
      res_t        r;
      logic [37:0] align_mask;
      logic        is_store;
      r = '0;
      r.fault_code = FAULT_NONE;
      case (it.mode)
        MODE_LOAD, MODE_STORE: begin
          is_store   = (it.mode == MODE_STORE);
          align_mask = (38'd1 << it.access_size_log2) - 38'd1;
          if ((it.address & align_mask) != '0) begin
            r.fault_code = is_store ? FAULT_STORE_MISALIGNED : FAULT_LOAD_MISALIGNED;
          end else if (it.address < win_lo || it.address > win_hi) begin
            r.fault_code = is_store ? FAULT_STORE_ACCESS : FAULT_LOAD_ACCESS;
          end else begin
            r.forward = 1'b1;
            // only the low 32 bits take part in the stack compare
            if (is_store && it.address[31:0] >= stack_base && it.address[31:0] < hwm) begin
              hwm = it.address[31:0] & MARK_MASK;
            end
          end
          if (r.fault_code != FAULT_NONE) begin
            r.tval     = it.address;
            r.fault_pc = it.instruction_address;
          end
        end
        MODE_MARK_WRITE: hwm = it.address[31:0] & MARK_MASK;
        default: ;
      endcase
      r.mark_now = hwm;
      verdicts_due = {verdicts_due, r};
    endfunction

    function void flag(string what, logic [37:0] want, logic [37:0] got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch in %s of result %0d: expected %h, got %h",
                 what, results_seen, want, got);
      end
    endfunction

    function void check_verdict(res_t got);
      res_t want;
      results_seen++;
      if (verdicts_due.size() == 0) begin
        flag("unexpected result, mark", '0, 38'(got.mark_now));
        return;
      end
      want = verdicts_due.pop_front();
      if (got.fault_code !== want.fault_code)
        flag("fault_code", 38'(want.fault_code), 38'(got.fault_code));
      if (got.forward !== want.forward)
        flag("forward", 38'(want.forward), 38'(got.forward));
      if (got.tval !== want.tval)
        flag("tval", want.tval, got.tval);
      if (got.fault_pc !== want.fault_pc)
        flag("fault_pc", 38'(want.fault_pc), 38'(got.fault_pc));
      if (got.mark_now !== want.mark_now)
        flag("mark_now", 38'(want.mark_now), 38'(got.mark_now));
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wen;
  logic [1:0]  cfg_index;
  logic [37:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  mode;
  logic [37:0] address;
  logic [1:0]  access_size_log2;
  logic [31:0] instruction_address;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  fault_code;
  logic        forward;
  logic [37:0] tval;
  logic [31:0] fault_pc;
  logic [31:0] mark_now;

  access_verdict_board sb = new();

  int send_gap_pct = 14;
  int recv_gap_pct = 47;
  int stall_cycles = 0;

  memory_access_checker_stack_hwm u_top (.*);

  always #10 clk = ~clk;

  // Result side: random ready, or a long hold-off when one is requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_cycles > 0) begin
        stall_cycles = stall_cycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
    end
  end

  // Compare every accepted result
  always @(posedge clk) begin : result_check
    res_t got;
    if (!rst && out_valid && out_ready) begin
      got = '{fault_t'(fault_code), forward, tval, fault_pc, mark_now};
      sb.check_verdict(got);
    end
  end

  // Offer one item, with random gaps first; entered and left at a falling edge
  task automatic send_item(input item_t it, input int hold = 0);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid            <= 1'b1;
    mode                <= it.mode;
    address             <= it.address;
    access_size_log2    <= it.access_size_log2;
    instruction_address <= it.instruction_address;
    do @(posedge clk); while (!in_ready);
    sb.predict_access(it);
    if (hold > 0) stall_cycles = hold;
    @(negedge clk);
  endtask

  task automatic access(input mode_t m, input logic [37:0] a, input logic [1:0] sz,
                        input logic [31:0] pc = 32'h0000_1234);
    item_t it;
    it.mode                = m;
    it.address             = a;
    it.access_size_log2    = sz;
    it.instruction_address = pc;
    send_item(it);
  endtask

  // Register write; only issued while the block is idle
  task automatic cfg_write(input logic [1:0] idx, input logic [37:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.note_config(idx, data);
    @(negedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  // Stop offering, wait for every outstanding result, then cover the latency
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // New window and stack base for a random block
  task automatic random_config();
    logic [31:0] base;
    logic [37:0] lo;
    logic [37:0] hi;
    int          kind;
    base = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom);
    cfg_write(CFG_STACK_BASE, {6'($urandom_range(0, 63)), base});
    lo   = {6'd0, base & MARK_MASK} + 38'($urandom_range('h200, 'h3000));
    hi   = lo + 38'($urandom_range(0, 'h6000));
    kind = $urandom_range(0, 4);
    case (kind)
      0, 1: begin
        cfg_write(CFG_MAX_ADDRESS, ADDR_MAX);
        cfg_write(CFG_MIN_ADDRESS, '0);
      end
      2: begin
        cfg_write(CFG_MAX_ADDRESS, hi);
        cfg_write(CFG_MIN_ADDRESS, lo);
      end
      3: begin
        // upside-down window: every access faults
        cfg_write(CFG_MAX_ADDRESS, ADDR_MAX);
        cfg_write(CFG_MIN_ADDRESS, lo);
        cfg_write(CFG_MAX_ADDRESS, lo - 38'($urandom_range(1, 'h100)));
      end
      default: begin
        // arbitrary window; min may be clamped
        cfg_write(CFG_MAX_ADDRESS, {6'($urandom_range(0, 63)), 32'($urandom)});
        cfg_write(CFG_MIN_ADDRESS, {6'($urandom_range(0, 63)), 32'($urandom)});
      end
    endcase
    if ($urandom_range(0, 4) == 0) begin
      cfg_write(CFG_UNUSED, {6'($urandom_range(0, 63)), 32'($urandom)});
    end
  endtask

  // Mostly stack traffic around the base, with some wholly random items
  function automatic item_t next_access(bit open_block);
    item_t       it;
    int          pick;
    logic [31:0] a32;
    logic [1:0]  sz;
    sz = 2'($urandom_range(0, 3));
    it.access_size_log2    = sz;
    it.instruction_address = $urandom;
    pick = open_block ? 0 : $urandom_range(0, 99);
    a32  = sb.stack_base + 32'($urandom_range(0, 'h9000)) - 32'h400;
    if ($urandom_range(0, 9) != 0) a32 = a32 & ~((32'd1 << sz) - 32'd1);
    it.address = {($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'd0, a32};
    if (pick < 8) begin
      it.mode    = MODE_MARK_WRITE;
      it.address = {6'($urandom_range(0, 63)),
                    sb.stack_base + 32'($urandom_range('h800, 'h8000))};
    end else if (pick < 55) begin
      it.mode = MODE_STORE;
    end else if (pick < 80) begin
      it.mode = MODE_LOAD;
    end else begin
      it.mode    = mode_t'($urandom_range(0, 3));
      it.address = {6'($urandom_range(0, 63)), 32'($urandom)};
    end
    return it;
  endfunction

  // Stimulus
  initial begin
    clk                 = 1'b0;
    rst                 = 1'b1;
    cfg_wen             = 1'b0;
    cfg_index           = CFG_MIN_ADDRESS;
    cfg_data            = '0;
    in_valid            = 1'b0;
    mode                = MODE_LOAD;
    address             = '0;
    access_size_log2    = 2'd0;
    instruction_address = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Extremes, alignment, mark writes and stack stores in the full window
    access(MODE_LOAD, '0, 2'd0, 32'h0);
    access(MODE_LOAD, ADDR_MAX, 2'd0, 32'hffff_ffff);
    access(MODE_LOAD, 38'h1, 2'd1);
    access(MODE_LOAD, 38'h3f_ffff_fff8, 2'd3);
    access(MODE_STORE, 38'h2, 2'd2);
    access(MODE_STORE, 38'h4, 2'd3);
    access(MODE_MARK_WRITE, ADDR_MAX, 2'd3);
    access(MODE_STORE, 38'h1000, 2'd3);
    access(MODE_STORE, 38'h1008, 2'd3);
    access(MODE_STORE, 38'h0ff8, 2'd3);
    access(MODE_STORE, 38'h3f_0000_0800, 2'd2);
    access(MODE_UNUSED, ADDR_MAX, 2'd3, 32'hffff_ffff);
    access(MODE_MARK_WRITE, 38'h00_2000_001f, 2'd0);
    drain();

    // Narrow window at the stack base; base written with stray low bits
    cfg_write(CFG_STACK_BASE, 38'h3f_1000_000f);
    cfg_write(CFG_MAX_ADDRESS, 38'h00_1000_ffff);
    cfg_write(CFG_MIN_ADDRESS, 38'h00_1000_0000);
    access(MODE_STORE, 38'h0f_ffff_fff0, 2'd3);
    access(MODE_STORE, 38'h00_1000_0100, 2'd3);
    access(MODE_STORE, 38'h00_1001_0000, 2'd0);
    access(MODE_LOAD, 38'h00_1000_0003, 2'd2);
    access(MODE_LOAD, 38'h1, 2'd1);
    access(MODE_STORE, 38'h00_1000_00f0, 2'd3);
    drain();

    // Upside-down window, then a clamped min giving a single legal address
    cfg_write(CFG_MAX_ADDRESS, 38'h800);
    access(MODE_LOAD, 38'h900, 2'd0);
    access(MODE_STORE, 38'h00_1000_0000, 2'd3);
    drain();
    cfg_write(CFG_MIN_ADDRESS, ADDR_MAX);
    access(MODE_LOAD, 38'h800, 2'd3);
    drain();

    // Window of address zero only, top stack base, write to a missing register
    cfg_write(CFG_MAX_ADDRESS, '0);
    cfg_write(CFG_MIN_ADDRESS, '0);
    cfg_write(CFG_STACK_BASE, 38'h00_ffff_fff0);
    cfg_write(CFG_UNUSED, ADDR_MAX);
    access(MODE_LOAD, '0, 2'd3);
    access(MODE_STORE, 38'h8, 2'd3);
    drain();

    // Random blocks; idling swaps sides after a third, then stops
    for (int blk = 0; blk < 15; blk++) begin
      case (blk / 5)
        0: begin send_gap_pct = 14; recv_gap_pct = 47; end
        1: begin send_gap_pct = 47; recv_gap_pct = 14; end
        default: begin send_gap_pct = 0; recv_gap_pct = 0; end
      endcase
      drain();
      random_config();
      for (int n = 0; n < 50; n++) begin
        // long result stall while items keep coming
        send_item(next_access(n == 0), (n == 10 && blk % 5 == 2) ? 150 : 0);
      end
    end
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("memory_access_checker_stack_hwm regression: pass");
    end else begin
      $display("memory_access_checker_stack_hwm regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("memory_access_checker_stack_hwm regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
